// File: rtl/deq_pkg.sv
// Shared package for the resizable deque engine.
// Holds the capacity constant, the command and result transaction types, the opcode and
// status codes, and the controller-to-datapath command and status structs. No dependencies.
package deq_pkg;

    localparam int CAPACITY = 32;
    localparam int PTR_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Opcodes.
    localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_RESIZE     = 3'd4;
    localparam logic [2:0] OP_READ       = 3'd5;
    localparam logic [2:0] OP_WRITE      = 3'd6;
    localparam logic [2:0] OP_DUMP       = 3'd7;

    // Result status codes.
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_EMPTY   = 3'd2;
    localparam logic [2:0] ST_BAD_POS = 3'd3;
    localparam logic [2:0] ST_BAD_LEN = 3'd4;

    // Index sources for the ring address.
    localparam logic [1:0] IDX_COUNT = 2'd0;
    localparam logic [1:0] IDX_TOP   = 2'd1;
    localparam logic [1:0] IDX_POS   = 2'd2;
    localparam logic [1:0] IDX_CUR   = 2'd3;

    // Front pointer updates.
    localparam logic [1:0] FR_HOLD = 2'd0;
    localparam logic [1:0] FR_DEC  = 2'd1;
    localparam logic [1:0] FR_INC  = 2'd2;

    // Element count updates.
    localparam logic [1:0] CNT_HOLD = 2'd0;
    localparam logic [1:0] CNT_INC  = 2'd1;
    localparam logic [1:0] CNT_DEC  = 2'd2;
    localparam logic [1:0] CNT_LOAD = 2'd3;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] item_value;
        logic [5:0]         position;
        logic [6:0]         new_length;
    } t_deq_in;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [2:0]         status;
        logic               last_of_run;
        logic               has_data;
    } t_deq_out;

    typedef struct packed {
        logic       load;
        logic [1:0] idx_sel;
        logic       mem_we;
        logic       wdata_zero;
        logic       mem_re;
        logic [1:0] front_op;
        logic [1:0] cnt_op;
        logic       cur_inc;
        logic       emit;
        logic [2:0] status;
        logic       use_data;
        logic       last;
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic       full;
        logic       empty;
        logic       pos_bad;
        logic       len_bad;
        logic       grow;
        logic       fill_last;
        logic       dump_last;
    } t_dp_stat;

endpackage

// File: rtl/deq_dp.sv
// Datapath of the resizable deque engine: latched command, ring store, front pointer,
// element count, dump cursor and the result register. Depends on deq_pkg.
module deq_dp
    import deq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_deq_in  i_cmd,
    input  t_dp_cmd  i_ctl,
    output t_dp_stat o_stat,
    output logic     o_result_valid,
    output t_deq_out o_result
);

    logic [2:0]         r_op;
    logic signed [31:0] r_val;
    logic [5:0]         r_pos;
    logic [6:0]         r_nlen;
    logic [CNT_W-1:0]   r_cur;
    logic [PTR_W-1:0]   r_front;
    logic [CNT_W-1:0]   r_cnt;
    logic [31:0]        r_mem [CAPACITY];
    logic [31:0]        r_rdata;
    logic               r_res_valid;
    t_deq_out           r_res;

    logic [CNT_W-1:0]   n_idx;
    logic [CNT_W:0]     n_sum;
    logic [CNT_W:0]     n_wrap;
    logic [PTR_W-1:0]   n_slot;
    logic [31:0]        n_wdata;

    // Ring address: front plus index, folded once since both are below the capacity.
    always_comb begin
        case (i_ctl.idx_sel)
            IDX_COUNT: n_idx = r_cnt;
            IDX_TOP:   n_idx = CNT_W'(CAPACITY - 1);
            IDX_POS:   n_idx = CNT_W'(r_pos);
            default:   n_idx = r_cur;
        endcase
        n_sum  = (CNT_W + 1)'(r_front) + (CNT_W + 1)'(n_idx);
        n_wrap = n_sum - (CNT_W + 1)'(CAPACITY);
        n_slot = (n_sum >= (CNT_W + 1)'(CAPACITY)) ? n_wrap[PTR_W-1:0] : n_sum[PTR_W-1:0];
        n_wdata = i_ctl.wdata_zero ? 32'd0 : r_val;
    end

    always_comb begin
        o_stat.op        = r_op;
        o_stat.full      = (r_cnt == CNT_W'(CAPACITY));
        o_stat.empty     = (r_cnt == '0);
        o_stat.pos_bad   = ({1'b0, r_pos} >= 7'(r_cnt));
        o_stat.len_bad   = (r_nlen > 7'(CAPACITY));
        o_stat.grow      = (r_nlen > 7'(r_cnt));
        o_stat.fill_last = ((7'(r_cnt) + 7'd1) == r_nlen);
        o_stat.dump_last = (r_cur == r_cnt);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_op   <= i_cmd.opcode;
            r_val  <= i_cmd.item_value;
            r_pos  <= i_cmd.position;
            r_nlen <= i_cmd.new_length;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mem_we) begin
            r_mem[n_slot] <= n_wdata;
        end
        if (i_ctl.mem_re) begin
            r_rdata <= r_mem[n_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front     <= '0;
            r_cnt       <= '0;
            r_cur       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (i_ctl.load) begin
                r_cur <= '0;
            end else if (i_ctl.cur_inc) begin
                r_cur <= r_cur + CNT_W'(1);
            end
            case (i_ctl.front_op)
                FR_DEC:  r_front <= n_slot;
                FR_INC:  r_front <= (r_front == PTR_W'(CAPACITY - 1)) ? '0 : r_front + PTR_W'(1);
                default: r_front <= r_front;
            endcase
            case (i_ctl.cnt_op)
                CNT_INC:  r_cnt <= r_cnt + CNT_W'(1);
                CNT_DEC:  r_cnt <= r_cnt - CNT_W'(1);
                CNT_LOAD: r_cnt <= CNT_W'(r_nlen);
                default:  r_cnt <= r_cnt;
            endcase
            r_res_valid <= i_ctl.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.emit) begin
            r_res.read_value  <= i_ctl.use_data ? r_rdata : 32'd0;
            r_res.status      <= i_ctl.status;
            r_res.last_of_run <= i_ctl.last;
            r_res.has_data    <= i_ctl.use_data;
        end
    end

    assign o_result_valid = r_res_valid;
    assign o_result       = r_res;

endmodule

// File: rtl/deq_ctrl.sv
// Controller of the resizable deque engine: sequences each command into datapath steps.
// Depends on deq_pkg.
module deq_ctrl
    import deq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_ctl,
    output logic     o_busy
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_FILL   = 3'd2;
    localparam logic [2:0] S_RDWAIT = 3'd3;
    localparam logic [2:0] S_DUMP   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        o_ctl      = '0;
        o_ctl.last = 1'b1;
        n_state    = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                unique case (i_stat.op)
                    OP_PUSH_BACK: begin
                        o_ctl.emit = 1'b1;
                        if (i_stat.full) begin
                            o_ctl.status = ST_FULL;
                        end else begin
                            o_ctl.idx_sel = IDX_COUNT;
                            o_ctl.mem_we  = 1'b1;
                            o_ctl.cnt_op  = CNT_INC;
                        end
                    end
                    OP_PUSH_FRONT: begin
                        o_ctl.emit = 1'b1;
                        if (i_stat.full) begin
                            o_ctl.status = ST_FULL;
                        end else begin
                            o_ctl.idx_sel  = IDX_TOP;
                            o_ctl.mem_we   = 1'b1;
                            o_ctl.front_op = FR_DEC;
                            o_ctl.cnt_op   = CNT_INC;
                        end
                    end
                    OP_POP_FRONT: begin
                        o_ctl.emit = 1'b1;
                        if (i_stat.empty) begin
                            o_ctl.status = ST_EMPTY;
                        end else begin
                            o_ctl.front_op = FR_INC;
                            o_ctl.cnt_op   = CNT_DEC;
                        end
                    end
                    OP_POP_BACK: begin
                        o_ctl.emit = 1'b1;
                        if (i_stat.empty) begin
                            o_ctl.status = ST_EMPTY;
                        end else begin
                            o_ctl.cnt_op = CNT_DEC;
                        end
                    end
                    OP_RESIZE: begin
                        if (i_stat.len_bad) begin
                            o_ctl.emit   = 1'b1;
                            o_ctl.status = ST_BAD_LEN;
                        end else if (i_stat.grow) begin
                            o_ctl.idx_sel    = IDX_COUNT;
                            o_ctl.mem_we     = 1'b1;
                            o_ctl.wdata_zero = 1'b1;
                            o_ctl.cnt_op     = CNT_INC;
                            o_ctl.emit       = i_stat.fill_last;
                            n_state          = i_stat.fill_last ? S_IDLE : S_FILL;
                        end else begin
                            o_ctl.cnt_op = CNT_LOAD;
                            o_ctl.emit   = 1'b1;
                        end
                    end
                    OP_READ: begin
                        if (i_stat.pos_bad) begin
                            o_ctl.emit   = 1'b1;
                            o_ctl.status = ST_BAD_POS;
                        end else begin
                            o_ctl.idx_sel = IDX_POS;
                            o_ctl.mem_re  = 1'b1;
                            n_state       = S_RDWAIT;
                        end
                    end
                    OP_WRITE: begin
                        o_ctl.emit = 1'b1;
                        if (i_stat.pos_bad) begin
                            o_ctl.status = ST_BAD_POS;
                        end else begin
                            o_ctl.idx_sel = IDX_POS;
                            o_ctl.mem_we  = 1'b1;
                        end
                    end
                    OP_DUMP: begin
                        if (i_stat.empty) begin
                            o_ctl.emit = 1'b1;
                        end else begin
                            o_ctl.idx_sel = IDX_CUR;
                            o_ctl.mem_re  = 1'b1;
                            o_ctl.cur_inc = 1'b1;
                            n_state       = S_DUMP;
                        end
                    end
                endcase
            end
            S_FILL: begin
                o_ctl.idx_sel    = IDX_COUNT;
                o_ctl.mem_we     = 1'b1;
                o_ctl.wdata_zero = 1'b1;
                o_ctl.cnt_op     = CNT_INC;
                if (i_stat.fill_last) begin
                    o_ctl.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_RDWAIT: begin
                o_ctl.emit     = 1'b1;
                o_ctl.use_data = 1'b1;
                n_state        = S_IDLE;
            end
            S_DUMP: begin
                // The cursor already points past the element whose data is now ready.
                o_ctl.emit     = 1'b1;
                o_ctl.use_data = 1'b1;
                o_ctl.last     = i_stat.dump_last;
                if (i_stat.dump_last) begin
                    n_state = S_IDLE;
                end else begin
                    o_ctl.idx_sel = IDX_CUR;
                    o_ctl.mem_re  = 1'b1;
                    o_ctl.cur_inc = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// File: rtl/resizable_deque_engine.sv
// Top level of the resizable deque engine: a deque of signed 32-bit words in a ring store.
// Instantiates deq_ctrl and deq_dp; depends on deq_pkg.
//
// Usage: a command transaction (opcode, item_value, position, new_length on i_cmd) is taken
// at a rising clock edge where start is high and busy is low. Results come back on o_result,
// each valid for exactly one cycle while o_result_valid is high. The receiver cannot stall
// the block, so every result must be captured in the cycle it is shown.
//
// Timing: after the accepting edge the controller passes through its execute state, and the result
// appears in the following cycle, in which busy is already low again. Push, pop, write,
// shrinking resize and every flagged command therefore finish in the execute state. A read
// adds a wait state for the registered read port of the ring store. A growing resize
// writes one zero per cycle through the single store write port, from the current length
// up to new_length. A dump streams one element per cycle after a read lead-in, with
// last_of_run on the final one.
//
// Reset (i_rst_n low at a clock edge) empties the deque: the front pointer and length go
// to zero and any command in flight is dropped. Store contents are not cleared; every slot
// inside the length is written before it can be read.
module resizable_deque_engine
    import deq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_deq_in  i_cmd,
    output logic     o_result_valid,
    output t_deq_out o_result
);

    t_dp_cmd  w_ctl;
    t_dp_stat w_stat;

    // The controller reads only the summary flags of the datapath and drives its steps.
    deq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (w_stat),
        .o_ctl   (w_ctl),
        .o_busy  (busy)
    );

    // The datapath holds all storage and the result register.
    deq_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (i_cmd),
        .i_ctl          (w_ctl),
        .o_stat         (w_stat),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

endmodule

// File: tb/sv/resizable_deque_engine_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for resizable_deque_engine: a directed table, then random commands.
// Expected results come from a behavioral deque predictor in this file; depends on deq_pkg.
module resizable_deque_engine_tb;
    import deq_pkg::*;

    localparam int N_DIRECTED = 25;
    localparam int N_RANDOM   = 250;
    // The final stretch of random commands is sent back to back, with no idle gaps.
    localparam int N_QUIET    = 40;

    // One row of the directed table. When use_literal is set, the expected result is the
    // literal in want instead of the predictor's output; the predictor still tracks state.
    typedef struct packed {
        t_deq_in  cmd;
        logic     use_literal;
        t_deq_out want;
    } t_dir_row;

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    logic     busy;
    t_deq_in  i_cmd;
    logic     o_result_valid;
    t_deq_out o_result;

    // Side-band info that travels with the command being offered.
    logic     drv_use_literal;
    t_deq_out drv_want;

    // Predictor state: a ring of words, the front index and the element count.
    logic signed [31:0] ring_words [CAPACITY];
    logic [PTR_W-1:0]   ring_front;
    logic [CNT_W-1:0]   ring_len;

    // Results that one command produces, and the ordered store of results still owed.
    t_deq_out step_results [$];
    t_deq_out expected_results [$];

    int accepted_count;
    int mismatch_count;

    t_dir_row directed_rows [N_DIRECTED];

    resizable_deque_engine dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_deq_in cmd_of(logic [2:0] op, logic signed [31:0] val,
                                       logic [5:0] pos, logic [6:0] nlen);
        t_deq_in c;
        c.opcode     = op;
        c.item_value = val;
        c.position   = pos;
        c.new_length = nlen;
        return c;
    endfunction

    function automatic t_deq_out res_of(logic signed [31:0] val, logic [2:0] st,
                                        logic last, logic data);
        t_deq_out r;
        r.read_value  = val;
        r.status      = st;
        r.last_of_run = last;
        r.has_data    = data;
        return r;
    endfunction

    // Ring slot that holds the element idx places behind the front.
    function automatic int slot_at(int idx);
        return (int'(ring_front) + idx) % CAPACITY;
    endfunction

    // Applies one command to the predictor state and leaves its results in step_results.
    // Every failed command leaves the state untouched and reports a single status result.
    function automatic void deque_model_step(t_deq_in c);
        int n;
        step_results.delete();
        case (c.opcode)
            OP_PUSH_BACK, OP_PUSH_FRONT: begin
                if (ring_len >= CAPACITY) begin
                    step_results = {step_results, res_of(32'sd0, ST_FULL, 1'b1, 1'b0)};
                end else begin
                    if (c.opcode == OP_PUSH_BACK) begin
                        ring_words[slot_at(int'(ring_len))] = c.item_value;
                    end else begin
                        ring_front = PTR_W'((int'(ring_front) + CAPACITY - 1) % CAPACITY);
                        ring_words[ring_front] = c.item_value;
                    end
                    ring_len = ring_len + CNT_W'(1);
                    step_results = {step_results, res_of(32'sd0, ST_OK, 1'b1, 1'b0)};
                end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
                if (ring_len == 0) begin
                    step_results = {step_results, res_of(32'sd0, ST_EMPTY, 1'b1, 1'b0)};
                end else begin
                    // Popping the front moves the front index; popping the back only
                    // shortens the deque.
                    if (c.opcode == OP_POP_FRONT)
                        ring_front = PTR_W'((int'(ring_front) + 1) % CAPACITY);
                    ring_len = ring_len - CNT_W'(1);
                    step_results = {step_results, res_of(32'sd0, ST_OK, 1'b1, 1'b0)};
                end
            end
            OP_RESIZE: begin
                if (c.new_length > CAPACITY) begin
                    step_results = {step_results, res_of(32'sd0, ST_BAD_LEN, 1'b1, 1'b0)};
                end else begin
                    // Growing fills the new tail slots with zero; shrinking drops the tail.
                    for (n = int'(ring_len); n < int'(c.new_length); n++)
                        ring_words[slot_at(n)] = 32'sd0;
                    ring_len = CNT_W'(c.new_length);
                    step_results = {step_results, res_of(32'sd0, ST_OK, 1'b1, 1'b0)};
                end
            end
            OP_READ: begin
                if (c.position >= ring_len)
                    step_results = {step_results, res_of(32'sd0, ST_BAD_POS, 1'b1, 1'b0)};
                else
                    step_results = {step_results,
                                    res_of(ring_words[slot_at(int'(c.position))],
                                           ST_OK, 1'b1, 1'b1)};
            end
            OP_WRITE: begin
                if (c.position >= ring_len) begin
                    step_results = {step_results, res_of(32'sd0, ST_BAD_POS, 1'b1, 1'b0)};
                end else begin
                    ring_words[slot_at(int'(c.position))] = c.item_value;
                    step_results = {step_results, res_of(32'sd0, ST_OK, 1'b1, 1'b0)};
                end
            end
            default: begin
                // Dump: one result per element from front to back, last one marked.
                // An empty deque still answers with a single data-less result.
                if (ring_len == 0) begin
                    step_results = {step_results, res_of(32'sd0, ST_OK, 1'b1, 1'b0)};
                end else begin
                    for (n = 0; n < int'(ring_len); n++)
                        step_results = {step_results,
                                        res_of(ring_words[slot_at(n)], ST_OK,
                                               n == int'(ring_len) - 1, 1'b1)};
                end
            end
        endcase
    endfunction

    // Monitor. Everything is sampled at the rising edge, before the block's registers
    // update. A result shown in this cycle belongs to a command accepted earlier, so it is
    // checked before the command accepted at the same edge is predicted.
    always @(posedge i_clk) begin
        t_deq_out exp_res;
        if (i_rst_n) begin
            if (o_result_valid) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result: read_value %0d status %0d last %0b data %0b",
                           o_result.read_value, o_result.status, o_result.last_of_run,
                           o_result.has_data);
                    mismatch_count++;
                end else begin
                    exp_res = expected_results[0];
                    expected_results.delete(0);
                    if (o_result.read_value !== exp_res.read_value) begin
                        $error("read_value: expected %0d, got %0d",
                               exp_res.read_value, o_result.read_value);
                        mismatch_count++;
                    end
                    if (o_result.status !== exp_res.status) begin
                        $error("status: expected %0d, got %0d",
                               exp_res.status, o_result.status);
                        mismatch_count++;
                    end
                    if (o_result.last_of_run !== exp_res.last_of_run) begin
                        $error("last_of_run: expected %0b, got %0b",
                               exp_res.last_of_run, o_result.last_of_run);
                        mismatch_count++;
                    end
                    if (o_result.has_data !== exp_res.has_data) begin
                        $error("has_data: expected %0b, got %0b",
                               exp_res.has_data, o_result.has_data);
                        mismatch_count++;
                    end
                end
            end
            if (start && !busy) begin
                accepted_count++;
                deque_model_step(i_cmd);
                if (drv_use_literal)
                    expected_results = {expected_results, drv_want};
                else
                    foreach (step_results[k])
                        expected_results = {expected_results, step_results[k]};
            end
        end
    end

    // Offers one command from a falling edge and holds it until the block accepts the
    // transaction. Returns at the falling edge after acceptance with start still high, so
    // the caller either presents the next command or drops start without a glitch.
    task automatic offer_command(t_deq_in c, logic use_literal, t_deq_out want);
        int target;
        target = accepted_count + 1;
        start           <= 1'b1;
        i_cmd           <= c;
        drv_use_literal <= use_literal;
        drv_want        <= want;
        wait (accepted_count == target);
        @(negedge i_clk);
    endtask

    // Random idle burst between commands; never in the quiet tail of the run.
    task automatic maybe_idle(bit allow);
        if (allow && $urandom_range(3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(9, 1)) @(negedge i_clk);
        end
    endtask

    // Random command with well-formed content most of the time: positions mostly inside
    // the current length, resizes mostly to small lengths, and some out-of-range values so
    // every flagged case keeps showing up.
    function automatic t_deq_in random_command();
        int         pick;
        int         sel;
        logic [2:0] op;
        logic [5:0] pos;
        logic [6:0] nlen;
        pick = $urandom_range(99);
        if (pick < 22)      op = OP_PUSH_BACK;
        else if (pick < 38) op = OP_PUSH_FRONT;
        else if (pick < 48) op = OP_POP_FRONT;
        else if (pick < 58) op = OP_POP_BACK;
        else if (pick < 66) op = OP_RESIZE;
        else if (pick < 80) op = OP_READ;
        else if (pick < 92) op = OP_WRITE;
        else                op = OP_DUMP;
        // The predictor's length may trail a command still in flight; that only shifts
        // the odds, never the checking.
        if (ring_len != 0 && $urandom_range(3) != 0)
            pos = 6'($urandom_range(int'(ring_len) - 1));
        else
            pos = 6'($urandom_range(63));
        sel = $urandom_range(9);
        if (sel < 7)       nlen = 7'($urandom_range(12));
        else if (sel == 7) nlen = 7'($urandom_range(CAPACITY));
        else if (sel == 8) nlen = 7'($urandom_range(127, CAPACITY + 1));
        else               nlen = 7'(ring_len);
        return cmd_of(op, $urandom(), pos, nlen);
    endfunction

    // Stimulus: reset, the directed table, the random commands, then the drain.
    initial begin
        t_deq_out no_literal;
        t_deq_out ok_plain;
        int       idx;
        int       drain;

        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_cmd           = '0;
        drv_use_literal = 1'b0;
        drv_want        = '0;
        ring_front      = '0;
        ring_len        = '0;
        accepted_count  = 0;
        mismatch_count  = 0;

        no_literal = '0;
        ok_plain   = res_of(32'sd0, ST_OK, 1'b1, 1'b0);

        // Directed table. Literal expectations cover the empty-deque and range checks, the
        // first two pushes and the full-deque pushes; everything else goes through the predictor.
        directed_rows[0]  = {cmd_of(OP_POP_FRONT, 32'sd0, 6'd0, 7'd0), 1'b1,
                             res_of(32'sd0, ST_EMPTY, 1'b1, 1'b0)};
        directed_rows[1]  = {cmd_of(OP_POP_BACK, -32'sd1, 6'd63, 7'd127), 1'b1,
                             res_of(32'sd0, ST_EMPTY, 1'b1, 1'b0)};
        directed_rows[2]  = {cmd_of(OP_READ, 32'sd0, 6'd0, 7'd0), 1'b1,
                             res_of(32'sd0, ST_BAD_POS, 1'b1, 1'b0)};
        directed_rows[3]  = {cmd_of(OP_WRITE, 32'sh1234_5678, 6'd63, 7'd0), 1'b1,
                             res_of(32'sd0, ST_BAD_POS, 1'b1, 1'b0)};
        directed_rows[4]  = {cmd_of(OP_DUMP, 32'sd0, 6'd0, 7'd0), 1'b1, ok_plain};
        directed_rows[5]  = {cmd_of(OP_RESIZE, 32'sd0, 6'd0, 7'(CAPACITY + 1)), 1'b1,
                             res_of(32'sd0, ST_BAD_LEN, 1'b1, 1'b0)};
        directed_rows[6]  = {cmd_of(OP_RESIZE, 32'sd0, 6'd0, 7'd127), 1'b1,
                             res_of(32'sd0, ST_BAD_LEN, 1'b1, 1'b0)};
        directed_rows[7]  = {cmd_of(OP_PUSH_BACK, 32'sh7FFF_FFFF, 6'd0, 7'd0), 1'b1,
                             ok_plain};
        // Push front on a front index of zero wraps around the ring.
        directed_rows[8]  = {cmd_of(OP_PUSH_FRONT, 32'sh8000_0000, 6'd0, 7'd0), 1'b1,
                             ok_plain};
        directed_rows[9]  = {cmd_of(OP_PUSH_BACK, -32'sd1, 6'd0, 7'd0), 1'b0, no_literal};
        directed_rows[10] = {cmd_of(OP_READ, 32'sd0, 6'd0, 7'd0), 1'b0, no_literal};
        directed_rows[11] = {cmd_of(OP_WRITE, 32'sh5555_5555, 6'd2, 7'd0), 1'b0,
                             no_literal};
        directed_rows[12] = {cmd_of(OP_READ, 32'sd0, 6'd2, 7'd0), 1'b0, no_literal};
        // Index equal to the length is just out of range.
        directed_rows[13] = {cmd_of(OP_READ, 32'sd0, 6'd3, 7'd0), 1'b1,
                             res_of(32'sd0, ST_BAD_POS, 1'b1, 1'b0)};
        directed_rows[14] = {cmd_of(OP_DUMP, 32'sd0, 6'd0, 7'd0), 1'b0, no_literal};
        directed_rows[15] = {cmd_of(OP_RESIZE, 32'sd0, 6'd0, 7'd6), 1'b0, no_literal};
        // Resize to the current length is accepted and changes nothing.
        directed_rows[16] = {cmd_of(OP_RESIZE, 32'sd0, 6'd0, 7'd6), 1'b0, no_literal};
        directed_rows[17] = {cmd_of(OP_DUMP, 32'sd0, 6'd0, 7'd0), 1'b0, no_literal};
        directed_rows[18] = {cmd_of(OP_RESIZE, 32'sd0, 6'd0, 7'd2), 1'b0, no_literal};
        directed_rows[19] = {cmd_of(OP_POP_BACK, 32'sd0, 6'd0, 7'd0), 1'b0, no_literal};
        directed_rows[20] = {cmd_of(OP_POP_FRONT, 32'sd0, 6'd0, 7'd0), 1'b0, no_literal};
        directed_rows[21] = {cmd_of(OP_RESIZE, 32'sd0, 6'd0, 7'(CAPACITY)), 1'b0,
                             no_literal};
        directed_rows[22] = {cmd_of(OP_PUSH_FRONT, 32'sd7, 6'd0, 7'd0), 1'b1,
                             res_of(32'sd0, ST_FULL, 1'b1, 1'b0)};
        directed_rows[23] = {cmd_of(OP_PUSH_BACK, 32'sd9, 6'd0, 7'd0), 1'b1,
                             res_of(32'sd0, ST_FULL, 1'b1, 1'b0)};
        // A dump of a full deque gives the longest burst of results.
        directed_rows[24] = {cmd_of(OP_DUMP, 32'sd0, 6'd0, 7'd0), 1'b0, no_literal};

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (idx = 0; idx < N_DIRECTED; idx++) begin
            offer_command(directed_rows[idx].cmd, directed_rows[idx].use_literal,
                          directed_rows[idx].want);
            maybe_idle(1'b1);
        end

        for (idx = 0; idx < N_RANDOM; idx++) begin
            offer_command(random_command(), 1'b0, no_literal);
            maybe_idle(idx < N_RANDOM - N_QUIET);
        end
        start <= 1'b0;

        // Wait for every owed result, with a bound, then keep watching so that any
        // stray result after the last one is still caught.
        for (drain = 0; drain < 400 && expected_results.size() != 0; drain++)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $error("%0d expected results never arrived", expected_results.size());
            mismatch_count++;
        end

        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog: far longer than the slowest correct run needs.
    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
